### design/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package tcce_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int TAB_WIDTH = 8;

    // widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int LOC_W  = 11;
    localparam int DATA_W = 16;
    localparam int IDX_W  = 11;

    // rows that move up during a scroll
    localparam int COPY_LEN = (ROWS - 1) * COLUMNS;

    // operation codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BLANK    = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;

    localparam logic [7:0] RESET_ATTR = 8'h1F;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic put;
        logic read;
        logic home;
        logic cnt_clear;
        logic copy;
        logic fill;
        logic fill_init;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       scroll;
        logic       copy_done;
        logic       fill_done;
        logic       out_free;
    } status_t;

endpackage

### design/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// 80 x 25 text screen with cursor: put character, clear screen, read cell
// ----------------------------------------------------------------------------
// Every request yields one result carrying the cursor location after the
// operation (row * 80 + column) and, for a read, the cell (attribute in the
// high byte, character in the low byte; zero for anything else or for a read
// past the last cell). A plain put, a read or an unused code passes through
// accept, execute against the single-port screen memory and load of the
// result register. A put that passes the last row scrolls the screen one row
// up through the same memory port, one cell a cycle: a copy sweep moves the
// rows up, then a fill sweep blanks the last row. A clear sweeps all 2000
// cells. After reset the block runs a clearing pass that blanks the screen
// with attribute 0x1F; s_tready stays low until it ends, while attribute
// writes are taken at any time. A finished result waits in its own register,
// so the next request is accepted while the previous result is still pending
// on the master side.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_location[10:0], cell_data[26:11], zero pad
    // attribute register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // attribute_byte[7:0]
);

    tcce_pkg::cmd_t    cmd;
    tcce_pkg::status_t status;

    logic [tcce_pkg::LOC_W-1:0]  out_loc;
    logic [tcce_pkg::DATA_W-1:0] out_data;

    // sequencer
    tcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // screen memory, cursor and result register
    tcce_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_func   (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_index  (s_tdata[18:8]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_loc   (out_loc),
        .out_data  (out_data)
    );

    // attribute register takes a write in any cycle
    assign cfg_ready = 1'b1;

    assign m_tdata = {5'd0, out_data, out_loc};

endmodule

### design/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// sequencer for put, clear, read, scroll and the reset clearing pass
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tcce_pkg::status_t status,
    output tcce_pkg::cmd_t    cmd
);

    tcce_pkg::state_t state_reg;
    tcce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcce_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::ST_INIT:
            begin
                if (status.fill_done)
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tcce_pkg::ST_EXEC;
                end
            end
            tcce_pkg::ST_EXEC:
            begin
                case (status.func)
                    tcce_pkg::FUNC_PUT:
                    begin
                        state_next = status.scroll ? tcce_pkg::ST_COPY
                                                   : tcce_pkg::ST_RESULT;
                    end
                    tcce_pkg::FUNC_CLEAR: state_next = tcce_pkg::ST_FILL;
                    default:              state_next = tcce_pkg::ST_RESULT;
                endcase
            end
            tcce_pkg::ST_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = tcce_pkg::ST_FILL;
                end
            end
            tcce_pkg::ST_FILL:
            begin
                if (status.fill_done)
                begin
                    state_next = tcce_pkg::ST_RESULT;
                end
            end
            tcce_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default: state_next = tcce_pkg::ST_INIT;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tcce_pkg::ST_INIT:
            begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
            end
            tcce_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            tcce_pkg::ST_EXEC:
            begin
                case (status.func)
                    tcce_pkg::FUNC_PUT:
                    begin
                        cmd.put       = 1'b1;
                        cmd.cnt_clear = 1'b1;
                    end
                    tcce_pkg::FUNC_CLEAR:
                    begin
                        cmd.home      = 1'b1;
                        cmd.cnt_clear = 1'b1;
                    end
                    tcce_pkg::FUNC_READ: cmd.read = 1'b1;
                    default:             cmd = '0;
                endcase
            end
            tcce_pkg::ST_COPY:   cmd.copy     = 1'b1;
            tcce_pkg::ST_FILL:   cmd.fill     = 1'b1;
            tcce_pkg::ST_RESULT: cmd.load_out = status.out_free;
            default:             cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == tcce_pkg::ST_EXEC))
        else $error("accepted request did not start execution");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == tcce_pkg::ST_IDLE))
        else $error("result load not followed by idle");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcce_pkg::ST_COPY || state_reg == tcce_pkg::ST_FILL ||
         state_reg == tcce_pkg::ST_INIT) |-> !s_tready)
        else $error("request taken during a memory sweep");

    a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.copy && cmd.fill))
        else $error("copy and fill issued together");
`endif

endmodule

### design/tcce_dpath.sv
// ----------------------------------------------------------------------------
// tcce_dpath
// screen memory, cursor, attribute, sweep counter and result register
// ----------------------------------------------------------------------------
module tcce_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcce_pkg::cmd_t                cmd,
    output tcce_pkg::status_t             status,
    input  logic [1:0]                    in_func,
    input  logic [7:0]                    in_char,
    input  logic [tcce_pkg::IDX_W-1:0]    in_index,
    input  logic                          cfg_valid,
    input  logic [7:0]                    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcce_pkg::LOC_W-1:0]    out_loc,
    output logic [tcce_pkg::DATA_W-1:0]   out_data
);

    logic [tcce_pkg::DATA_W-1:0] screen_mem [tcce_pkg::CELLS];

    logic [7:0]                  attr_reg;
    logic [1:0]                  func_reg;
    logic [7:0]                  char_reg;
    logic [tcce_pkg::IDX_W-1:0]  index_reg;
    logic                        in_range_reg;
    logic [tcce_pkg::COL_W-1:0]  col_reg;
    logic [tcce_pkg::ROW_W-1:0]  row_reg;
    logic [tcce_pkg::CNT_W-1:0]  cnt_reg;
    logic [tcce_pkg::DATA_W-1:0] rd_data_reg;
    logic                        out_valid_reg;
    logic [tcce_pkg::LOC_W-1:0]  out_loc_reg;
    logic [tcce_pkg::DATA_W-1:0] out_data_reg;

    logic [tcce_pkg::COL_W-1:0]  col_next;
    logic [tcce_pkg::ROW_W-1:0]  row_next;
    logic                        printable;
    logic                        scroll;
    logic                        copy_done;
    logic                        fill_done;
    logic                        we;
    logic                        re;
    logic [tcce_pkg::ADDR_W-1:0] waddr;
    logic [tcce_pkg::ADDR_W-1:0] raddr;
    logic [tcce_pkg::DATA_W-1:0] wdata;
    logic [tcce_pkg::ADDR_W-1:0] cur_pos;
    logic [tcce_pkg::LOC_W-1:0]  cur_loc;
    logic [7:0]                  blank_attr;

    // cursor move for a put
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        printable = 1'b0;
        case (char_reg)
            tcce_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - tcce_pkg::COL_W'(1);
                end
            end
            tcce_pkg::CH_TAB:
            begin
                col_next = (col_reg + tcce_pkg::COL_W'(tcce_pkg::TAB_WIDTH))
                           & ~tcce_pkg::COL_W'(tcce_pkg::TAB_WIDTH - 1);
            end
            tcce_pkg::CH_CR: col_next = '0;
            tcce_pkg::CH_LF:
            begin
                col_next = '0;
                row_next = row_reg + tcce_pkg::ROW_W'(1);
            end
            default:
            begin
                if (char_reg inside {[tcce_pkg::CH_BLANK:tcce_pkg::CH_PRINT_HI]})
                begin
                    printable = 1'b1;
                    col_next  = col_reg + tcce_pkg::COL_W'(1);
                end
            end
        endcase
        if (col_next >= tcce_pkg::COL_W'(tcce_pkg::COLUMNS))
        begin
            col_next = '0;
            row_next = row_next + tcce_pkg::ROW_W'(1);
        end
    end

    assign scroll    = (row_next >= tcce_pkg::ROW_W'(tcce_pkg::ROWS));
    assign copy_done = (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::COPY_LEN));
    assign fill_done = (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1));

    assign cur_pos = tcce_pkg::ADDR_W'(row_reg) * tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS)
                     + tcce_pkg::ADDR_W'(col_reg);
    assign cur_loc = tcce_pkg::LOC_W'(row_reg) * tcce_pkg::LOC_W'(tcce_pkg::COLUMNS)
                     + tcce_pkg::LOC_W'(col_reg);

    assign blank_attr = cmd.fill_init ? tcce_pkg::RESET_ATTR : attr_reg;

    // memory port selection
    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = cnt_reg[tcce_pkg::ADDR_W-1:0];
        raddr = index_reg[tcce_pkg::ADDR_W-1:0];
        wdata = {blank_attr, tcce_pkg::CH_BLANK};
        if (cmd.put)
        begin
            we    = printable;
            waddr = cur_pos;
            wdata = {attr_reg, char_reg};
        end
        else if (cmd.read)
        begin
            re = in_range_reg;
        end
        else if (cmd.copy)
        begin
            // read one row ahead, write the previous read one cell back
            re    = !copy_done;
            raddr = tcce_pkg::ADDR_W'(cnt_reg + tcce_pkg::CNT_W'(tcce_pkg::COLUMNS));
            we    = (cnt_reg != '0);
            waddr = tcce_pkg::ADDR_W'(cnt_reg - tcce_pkg::CNT_W'(1));
            wdata = rd_data_reg;
        end
        else if (cmd.fill)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            screen_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= screen_mem[raddr];
        end
    end

    // captured request, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg     <= in_char;
            index_reg    <= in_index;
            in_range_reg <= (in_index < tcce_pkg::IDX_W'(tcce_pkg::CELLS));
        end
        if (cmd.load_out)
        begin
            out_loc_reg  <= cur_loc;
            out_data_reg <= (func_reg == tcce_pkg::FUNC_READ && in_range_reg)
                            ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tcce_pkg::RESET_ATTR;
            func_reg      <= tcce_pkg::FUNC_PUT;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                func_reg <= in_func;
            end
            if (cmd.put)
            begin
                col_reg <= col_next;
                row_reg <= scroll ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1) : row_next;
            end
            else if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if ((cmd.copy && !copy_done) || (cmd.fill && !fill_done))
            begin
                cnt_reg <= cnt_reg + tcce_pkg::CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.func      = func_reg;
    assign status.scroll    = scroll;
    assign status.copy_done = copy_done;
    assign status.fill_done = fill_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_loc   = out_loc_reg;
    assign out_data  = out_data_reg;

endmodule
